/* sv/ssd_pkg.sv */
// Package: shared types, codes and constants for the seven-segment display driver.
package ssd_pkg;

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_ADDR = 2'd1,
        CMD_DATA = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        CFG_FONT_LOW  = 2'd0,
        CFG_FONT_HIGH = 2'd1,
        CFG_BOOT      = 2'd2
    } cfg_index_t;

    localparam int CFG_DATA_W = 40;
    localparam int RECIP_W    = 29;
    localparam int RECIP_SH   = 32;
    localparam int DIV10_SH   = 19;

    localparam logic [7:0]  DOT_BIT      = 8'b0010_0000;
    localparam logic [7:0]  DOT_CLEAR    = 8'b1101_1111;
    localparam logic [1:0]  BYTES_STORED = 2'd3;
    localparam logic [31:0] BOOT_RESET   = 32'd36;
    localparam logic [15:0] DIV10_MUL    = 16'd52429;

    // ceil(2^32 / 10^d); exact quotient for any 16-bit dividend
    function automatic logic [RECIP_W-1:0] recip(input logic [2:0] d);
        logic [RECIP_W-1:0] m;
        begin
            case (d)
                3'd1:    m = 29'd429496730;
                3'd2:    m = 29'd42949673;
                3'd3:    m = 29'd4294968;
                3'd4:    m = 29'd429497;
                default: m = '0;
            endcase
            return m;
        end
    endfunction

    function automatic logic [7:0] glyph(input logic [CFG_DATA_W-1:0] lo,
                                         input logic [CFG_DATA_W-1:0] hi,
                                         input logic [3:0] r);
        logic [7:0] g;
        begin
            case (r)
                4'd0:    g = lo[7:0];
                4'd1:    g = lo[15:8];
                4'd2:    g = lo[23:16];
                4'd3:    g = lo[31:24];
                4'd4:    g = lo[39:32];
                4'd5:    g = hi[7:0];
                4'd6:    g = hi[15:8];
                4'd7:    g = hi[23:16];
                4'd8:    g = hi[31:24];
                4'd9:    g = hi[39:32];
                default: g = '0;
            endcase
            return g;
        end
    endfunction

endpackage

/* sv/seven_segment_i2c_display.sv */
// Top level: multiplexed seven-segment display driver fed by bus write events.
//
//   channel   signals                          payload
//   in        in_valid / in_stall              cmd, data_byte
//   out       out_valid / out_stall            segments, digit_index, dot_on
//   cfg       cfg_we, cfg_index                cfg_data
//
// One item per cycle while out is not stalled; each transfer in gives one result.
// Stage 1 updates state and takes v / 10^d for the scanned digit with one
// reciprocal multiply; stage 2 takes the remainder by ten and the glyph.
// Reset clears scan, byte count and stored bytes and loads the boot patterns.
// A stall on out holds the result; in stalls only when both stages are full.
module seven_segment_i2c_display #(
    parameter int NUM_DIGITS = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     cmd,
    input  logic [7:0]                     data_byte,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [7:0]                     segments,
    output logic [1:0]                     digit_index,
    output logic                           dot_on,
    input  logic                           cfg_we,
    input  logic [1:0]                     cfg_index,
    input  logic [ssd_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int SCAN_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam logic [SCAN_W-1:0] SCAN_LAST = SCAN_W'(NUM_DIGITS - 1);

    logic [ssd_pkg::CFG_DATA_W-1:0] font_lo_reg, font_hi_reg;
    logic [31:0]                    boot_reg;
    // font as it stood at the last stored byte
    logic [ssd_pkg::CFG_DATA_W-1:0] glyph_lo_reg, glyph_hi_reg;

    logic [SCAN_W-1:0] scan_reg, scan_next;
    logic [1:0]        count_reg, count_next;
    logic [7:0]        rx0_reg, rx0_next, rx1_reg, rx1_next, rx2_reg, rx2_next;
    logic              boot_mode_reg, boot_mode_next;
    logic              store_byte;

    logic              s1_valid_reg;
    logic [15:0]       s1_q_reg, s1_q_next;
    logic [SCAN_W-1:0] s1_scan_reg;
    logic              s1_boot_reg;
    logic [7:0]        s1_bootpat_reg, s1_bootpat_next;
    logic              s1_dot_reg, s1_dot_next;

    logic              out_valid_reg;
    logic [7:0]        seg_reg, seg_next;
    logic [SCAN_W-1:0] idx_reg;

    logic              out_ready, s1_ready, in_xfer;
    logic [2:0]        d3;
    logic [1:0]        bsel;
    logic [15:0]       v;
    logic [44:0]       prod1;
    logic [31:0]       prod2;
    logic [12:0]       q10;
    logic [15:0]       rem16;
    logic [3:0]        r;

    assign out_ready = !out_valid_reg || !out_stall;
    assign s1_ready  = !s1_valid_reg || out_ready;
    assign in_stall  = !s1_ready;
    assign in_xfer   = in_valid && s1_ready;

    // state update for the accepted command
    always_comb
    begin
        scan_next      = scan_reg;
        count_next     = count_reg;
        rx0_next       = rx0_reg;
        rx1_next       = rx1_reg;
        rx2_next       = rx2_reg;
        boot_mode_next = boot_mode_reg;
        store_byte     = 1'b0;
        unique case (cmd)
            ssd_pkg::CMD_TICK:
            begin
                if (scan_reg == SCAN_LAST)
                    scan_next = '0;
                else
                    scan_next = scan_reg + 1'b1;
            end
            ssd_pkg::CMD_ADDR:
                count_next = '0;
            ssd_pkg::CMD_DATA:
            begin
                if (count_reg < ssd_pkg::BYTES_STORED)
                begin
                    unique case (count_reg)
                        2'd0:    rx0_next = data_byte;
                        2'd1:    rx1_next = data_byte;
                        default: rx2_next = data_byte;
                    endcase
                    count_next     = count_reg + 1'b1;
                    boot_mode_next = 1'b0;
                    store_byte     = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // stage 1: quotient by 10^d for the scanned digit
    always_comb
    begin
        d3    = 3'(scan_next);
        bsel  = 2'(d3);
        v     = {rx0_next, rx1_next};
        prod1 = v * ssd_pkg::recip(d3);
        if (d3 == 3'd0)
            s1_q_next = v;
        else
            s1_q_next = 16'(prod1[44:ssd_pkg::RECIP_SH]);
        if (d3 < 3'd4)
            s1_bootpat_next = boot_reg[{bsel, 3'b000} +: 8];
        else
            s1_bootpat_next = '0;
        s1_dot_next = (rx2_next == 8'(scan_next));
    end

    // stage 2: remainder by ten, glyph, dot, or the boot pattern in boot mode
    always_comb
    begin
        prod2 = s1_q_reg * ssd_pkg::DIV10_MUL;
        q10   = prod2[31:ssd_pkg::DIV10_SH];
        rem16 = s1_q_reg - ({3'b000, q10} << 3) - ({3'b000, q10} << 1);
        r     = rem16[3:0];
        if (s1_boot_reg)
            seg_next = s1_bootpat_reg;
        else
            seg_next = (ssd_pkg::glyph(glyph_lo_reg, glyph_hi_reg, r) & ssd_pkg::DOT_CLEAR)
                       | (s1_dot_reg ? ssd_pkg::DOT_BIT : 8'h00);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            font_lo_reg   <= '0;
            font_hi_reg   <= '0;
            glyph_lo_reg  <= '0;
            glyph_hi_reg  <= '0;
            boot_reg      <= ssd_pkg::BOOT_RESET;
            scan_reg      <= '0;
            count_reg     <= '0;
            rx0_reg       <= '0;
            rx1_reg       <= '0;
            rx2_reg       <= '0;
            boot_mode_reg <= 1'b1;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    ssd_pkg::CFG_FONT_LOW:  font_lo_reg <= cfg_data;
                    ssd_pkg::CFG_FONT_HIGH: font_hi_reg <= cfg_data;
                    ssd_pkg::CFG_BOOT:      boot_reg    <= cfg_data[31:0];
                    default: ;
                endcase
            end
            if (in_xfer)
            begin
                scan_reg      <= scan_next;
                count_reg     <= count_next;
                rx0_reg       <= rx0_next;
                rx1_reg       <= rx1_next;
                rx2_reg       <= rx2_next;
                boot_mode_reg <= boot_mode_next;
                if (store_byte)
                begin
                    glyph_lo_reg <= font_lo_reg;
                    glyph_hi_reg <= font_hi_reg;
                end
            end
            if (s1_ready)
                s1_valid_reg <= in_valid;
            if (out_ready)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_q_reg       <= s1_q_next;
            s1_scan_reg    <= scan_next;
            s1_boot_reg    <= boot_mode_next;
            s1_bootpat_reg <= s1_bootpat_next;
            s1_dot_reg     <= s1_dot_next;
        end
        if (out_ready && s1_valid_reg)
        begin
            seg_reg <= seg_next;
            idx_reg <= s1_scan_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign segments    = seg_reg;
    assign digit_index = 2'(idx_reg);
    assign dot_on      = seg_reg[5];

endmodule

/* dv/seven_segment_i2c_display_tb.sv */
// Testbench for seven_segment_i2c_display: directed table plus random bus frames.
module seven_segment_i2c_display_tb;

    localparam int          NUM_DIGITS    = 4;
    localparam int          SETTLE_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int          PHASES        = 8;
    localparam int          PHASE_ITEMS   = 125;
    localparam int          MAX_REPORTS   = 100;
    localparam logic [1:0]  CMD_UNUSED    = 2'd3;
    localparam logic [1:0]  CFG_NONE      = 2'd3;
    localparam bit          XFER          = 1'b0;
    localparam bit          REGW          = 1'b1;
    localparam logic [39:0] SEG_FONT_LOW  = 40'h66_4F_5B_06_3F;
    localparam logic [39:0] SEG_FONT_HIGH = 40'h6F_7F_07_7D_6D;

    typedef struct packed {
        logic [7:0] seg;
        logic [1:0] idx;
        logic       dot;
    } view_t;

    typedef struct packed {
        bit          wr;
        logic [1:0]  code;
        logic [39:0] value;
        bit          typed;
        view_t       want;
    } step_row_t;

    localparam int PLAN_LEN = 33;

    // kind, cmd or register, data, typed, {segments, digit, dot}
    step_row_t plan [PLAN_LEN] = '{
        '{XFER, ssd_pkg::CMD_TICK,      40'h00,         1'b1, '{8'h00, 2'd1, 1'b0}},
        '{XFER, ssd_pkg::CMD_TICK,      40'hFF,         1'b1, '{8'h00, 2'd2, 1'b0}},
        '{XFER, ssd_pkg::CMD_TICK,      40'h00,         1'b1, '{8'h00, 2'd3, 1'b0}},
        '{XFER, ssd_pkg::CMD_TICK,      40'h00,         1'b1, '{8'h24, 2'd0, 1'b1}},
        '{XFER, CMD_UNUSED,             40'hFF,         1'b1, '{8'h24, 2'd0, 1'b1}},
        '{REGW, ssd_pkg::CFG_BOOT,      40'hFFFFFFFF,   1'b0, '0},
        '{XFER, ssd_pkg::CMD_ADDR,      40'h00,         1'b1, '{8'hFF, 2'd0, 1'b1}},
        '{REGW, ssd_pkg::CFG_FONT_LOW,  SEG_FONT_LOW,   1'b0, '0},
        '{REGW, ssd_pkg::CFG_FONT_HIGH, SEG_FONT_HIGH,  1'b0, '0},
        '{XFER, ssd_pkg::CMD_DATA,      40'hFF,         1'b0, '0},
        '{XFER, ssd_pkg::CMD_DATA,      40'hFF,         1'b0, '0},
        '{XFER, ssd_pkg::CMD_DATA,      40'h03,         1'b0, '0},
        '{XFER, ssd_pkg::CMD_DATA,      40'h00,         1'b0, '0},
        '{XFER, ssd_pkg::CMD_TICK,      40'h00,         1'b0, '0},
        '{REGW, ssd_pkg::CFG_BOOT,      40'h00,         1'b0, '0},
        '{XFER, ssd_pkg::CMD_TICK,      40'h00,         1'b0, '0},
        '{XFER, ssd_pkg::CMD_ADDR,      40'h00,         1'b0, '0},
        '{XFER, ssd_pkg::CMD_DATA,      40'h00,         1'b0, '0},
        '{XFER, ssd_pkg::CMD_DATA,      40'h00,         1'b0, '0},
        '{XFER, ssd_pkg::CMD_DATA,      40'h04,         1'b0, '0},
        '{XFER, ssd_pkg::CMD_DATA,      40'hFF,         1'b0, '0},
        '{XFER, ssd_pkg::CMD_ADDR,      40'h00,         1'b0, '0},
        '{XFER, ssd_pkg::CMD_DATA,      40'h27,         1'b0, '0},
        '{XFER, ssd_pkg::CMD_DATA,      40'h0F,         1'b0, '0},
        '{XFER, ssd_pkg::CMD_DATA,      40'h02,         1'b0, '0},
        '{REGW, ssd_pkg::CFG_FONT_LOW,  40'hFFFFFFFFFF, 1'b0, '0},
        '{REGW, ssd_pkg::CFG_FONT_HIGH, 40'h00,         1'b0, '0},
        '{REGW, CFG_NONE,               40'hFFFFFFFFFF, 1'b0, '0},
        '{XFER, ssd_pkg::CMD_ADDR,      40'h00,         1'b0, '0},
        '{XFER, ssd_pkg::CMD_DATA,      40'h80,         1'b0, '0},
        '{XFER, ssd_pkg::CMD_TICK,      40'h00,         1'b0, '0},
        '{XFER, ssd_pkg::CMD_TICK,      40'h00,         1'b0, '0},
        '{XFER, ssd_pkg::CMD_TICK,      40'h00,         1'b0, '0}
    };

    logic        clk;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic [1:0]  cmd        = '0;
    logic [7:0]  data_byte  = '0;
    logic        out_valid;
    logic        out_stall  = 1'b0;
    logic [7:0]  segments;
    logic [1:0]  digit_index;
    logic        dot_on;
    logic        cfg_we     = 1'b0;
    logic [1:0]  cfg_index  = '0;
    logic [ssd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // display model state
    logic [39:0] font_lo;
    logic [39:0] font_hi;
    logic [31:0] boot_reg;
    logic [1:0]  scan_pos;
    logic [7:0]  pats [NUM_DIGITS];
    logic [1:0]  nbytes;
    logic [7:0]  rx_bytes [3];
    bit          at_boot;

    view_t       due_views [$];
    int          mismatches = 0;
    int          sent       = 0;
    int          stall_left = 0;
    bit          quiet      = 1'b0;
    int unsigned cycles     = 0;

    seven_segment_i2c_display #(.NUM_DIGITS(NUM_DIGITS)) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .cmd(cmd),
        .data_byte(data_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .segments(segments),
        .digit_index(digit_index),
        .dot_on(dot_on),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void load_boot_patterns();
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            pats[i] = (i < 4) ? boot_reg[8*i +: 8] : 8'h00;
        end
    endfunction

    function automatic void redraw_digits();
        logic [15:0] val;
        logic [3:0]  dig;
        begin
            val = {rx_bytes[0], rx_bytes[1]};
            for (int i = 0; i < NUM_DIGITS; i++)
            begin
                dig = 4'(val % 16'd10);
                pats[i] = ((dig < 4'd5) ? font_lo[8*dig +: 8] : font_hi[8*(dig-4'd5) +: 8])
                          & ssd_pkg::DOT_CLEAR;
                val = val / 16'd10;
            end
            if (rx_bytes[2] < NUM_DIGITS)
            begin
                pats[rx_bytes[2]] = pats[rx_bytes[2]] | ssd_pkg::DOT_BIT;
            end
        end
    endfunction

    function automatic void display_reset();
        font_lo  = '0;
        font_hi  = '0;
        boot_reg = ssd_pkg::BOOT_RESET;
        scan_pos = '0;
        nbytes   = '0;
        rx_bytes = '{8'h00, 8'h00, 8'h00};
        at_boot  = 1'b1;
        load_boot_patterns();
    endfunction

    function automatic void take_reg(input logic [1:0] idx, input logic [39:0] val);
        if (idx == ssd_pkg::CFG_FONT_LOW)
        begin
            font_lo = val;
        end
        else if (idx == ssd_pkg::CFG_FONT_HIGH)
        begin
            font_hi = val;
        end
        else if (idx == ssd_pkg::CFG_BOOT)
        begin
            boot_reg = val[31:0];
            if (at_boot)
            begin
                load_boot_patterns();
            end
        end
    endfunction

    function automatic view_t display_step(input logic [1:0] c, input logic [7:0] d);
        view_t v;
        begin
            if (c == ssd_pkg::CMD_TICK)
            begin
                scan_pos = (scan_pos == 2'(NUM_DIGITS - 1)) ? 2'd0 : scan_pos + 2'd1;
            end
            else if (c == ssd_pkg::CMD_ADDR)
            begin
                nbytes = '0;
            end
            else if (c == ssd_pkg::CMD_DATA && nbytes < ssd_pkg::BYTES_STORED)
            begin
                rx_bytes[nbytes] = d;
                nbytes = nbytes + 2'd1;
                at_boot = 1'b0;
                redraw_digits();
            end
            v.seg = pats[scan_pos];
            v.idx = scan_pos;
            v.dot = pats[scan_pos][5];
            return v;
        end
    endfunction

    task automatic send_item(input logic [1:0] c, input logic [7:0] d,
                             input bit typed = 1'b0, input view_t want = '0);
        view_t v;
        begin
            if (!quiet && $urandom_range(0, 4) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            in_valid  <= 1'b1;
            cmd       <= c;
            data_byte <= d;
            do @(posedge clk); while (in_stall);
            v = display_step(c, d);
            due_views.push_back(typed ? want : v);
            sent++;
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (due_views.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [39:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        take_reg(idx, val);
    endtask

    function automatic logic [39:0] pick_font();
        logic [31:0] a;
        logic [31:0] b;
        begin
            a = $urandom;
            b = $urandom;
            case ($urandom_range(0, 3))
                0:       return '0;
                1:       return '1;
                2:       return ($urandom_range(0, 1) == 0) ? SEG_FONT_LOW : SEG_FONT_HIGH;
                default: return {a[7:0], b};
            endcase
        end
    endfunction

    function automatic logic [7:0] value_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic retune();
        settle();
        reg_write(ssd_pkg::CFG_FONT_LOW, pick_font());
        reg_write(ssd_pkg::CFG_FONT_HIGH, pick_font());
        if ($urandom_range(0, 2) == 0)
        begin
            reg_write(ssd_pkg::CFG_BOOT, {8'h00, 32'($urandom)});
        end
        if ($urandom_range(0, 3) == 0)
        begin
            reg_write(CFG_NONE, pick_font());
        end
        cfg_we <= 1'b0;
    endtask

    task automatic maybe_ticks(input int most);
        repeat ($urandom_range(0, most))
            send_item(ssd_pkg::CMD_TICK, 8'($urandom_range(0, 255)));
    endtask

    // mostly whole frames: address, value high, value low, dot position
    task automatic bus_frame();
        int kind;
        begin
            kind = $urandom_range(0, 9);
            if (kind < 7)
            begin
                send_item(ssd_pkg::CMD_ADDR, 8'($urandom_range(0, 255)));
                maybe_ticks(1);
                send_item(ssd_pkg::CMD_DATA, value_byte());
                maybe_ticks(1);
                send_item(ssd_pkg::CMD_DATA, value_byte());
                send_item(ssd_pkg::CMD_DATA, ($urandom_range(0, 3) == 0) ?
                          8'($urandom_range(0, 255)) : 8'($urandom_range(0, 4)));
                maybe_ticks(6);
            end
            else if (kind == 7)
            begin
                send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            end
            else if (kind == 8)
            begin
                send_item(ssd_pkg::CMD_ADDR, 8'($urandom_range(0, 255)));
                repeat ($urandom_range(1, 2)) send_item(ssd_pkg::CMD_DATA, value_byte());
                maybe_ticks(2);
            end
            else
            begin
                repeat ($urandom_range(1, 3)) send_item(ssd_pkg::CMD_DATA, value_byte());
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 4);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        view_t want;
        if (out_valid && !out_stall)
        begin
            if (due_views.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("%0t unexpected transfer: seg %h digit %0d dot %0d",
                             $time, segments, digit_index, dot_on);
                end
            end
            else
            begin
                want = due_views.pop_front();
                if (segments !== want.seg || digit_index !== want.idx || dot_on !== want.dot)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display({"%0t expected seg %h digit %0d dot %0d,",
                                  " got seg %h digit %0d dot %0d"},
                                 $time, want.seg, want.idx, want.dot,
                                 segments, digit_index, dot_on);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        bit regs_open;
        regs_open = 1'b0;
        display_reset();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < PLAN_LEN; r++)
        begin
            if (plan[r].wr)
            begin
                if (!regs_open)
                begin
                    settle();
                end
                reg_write(plan[r].code, plan[r].value);
                regs_open = 1'b1;
            end
            else
            begin
                if (regs_open)
                begin
                    cfg_we <= 1'b0;
                end
                regs_open = 1'b0;
                send_item(plan[r].code, plan[r].value[7:0], plan[r].typed, plan[r].want);
            end
        end

        for (int p = 0; p < PHASES; p++)
        begin
            retune();
            quiet = (p == PHASES - 1);
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                bus_frame();
            end
        end

        settle();
        if (mismatches == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* seven_segment_i2c_display.f */
sv/ssd_pkg.sv
sv/seven_segment_i2c_display.sv
dv/seven_segment_i2c_display_tb.sv
